FILE: hdl/filtered_pd_servo_angle_core_assert.svh
// Assertion macros shared by the servo angle controller RTL.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef FILTERED_PD_SERVO_ANGLE_CORE_ASSERT_SVH
`define FILTERED_PD_SERVO_ANGLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FPSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fpsa_pkg.sv
// Types, widths and constants for the filtered PD servo angle controller.
// No dependencies; used by fpsa_div and filtered_pd_servo_angle_core.
package fpsa_pkg;

  // Field widths
  localparam int SAMPLE_W  = 12;
  localparam int ELAPSED_W = 24;
  localparam int ANGLE_W   = 8;
  localparam int DELTA_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Datapath widths
  localparam int FL_W      = 20;  // Q12.8 filtered level
  localparam int ERR_W     = 21;  // Q13.8 signed error
  localparam int DERR_W    = 22;  // error difference
  localparam int T_W       = 17;  // effective elapsed time, us
  localparam int MUL_A_W   = 19;
  localparam int MUL_B_W   = 22;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 36;
  localparam int PMAG_W    = 37;
  localparam int DGM_W     = 38;
  localparam int DLO_W     = 39;
  localparam int SPLIT_W   = 19;  // low slice of the derivative product
  localparam int DIV_NUM_W = 58;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam int TOT_W     = 60;
  localparam int FRAC_SH   = 24;
  localparam int DM_W      = TOT_W - FRAC_SH;

  // Constants
  localparam logic [15:0]        ALPHA_ONE   = 16'd32768;
  localparam logic [T_W-1:0]     DEFAULT_T   = 17'd10000;
  localparam logic [ELAPSED_W-1:0] MAX_T     = 24'd100000;
  localparam logic [MUL_B_W-1:0] US_PER_S    = 22'd1000000;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;
  localparam logic [ACC_W-1:0]   ROUND_HALF  = 36'd16384;
  localparam int                 FILT_SH     = 15;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PGAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DGAIN  = 2'd3;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] TARGET_RST = 12'd3;
  localparam logic [15:0]         ALPHA_RST  = 16'd3277;
  localparam logic [15:0]         PGAIN_RST  = 16'd655;
  localparam logic [15:0]         DGAIN_RST  = 16'd66;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample_mv;
    logic [ELAPSED_W-1:0] elapsed_us;
  } in_beat_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        servo_angle;
    logic signed [DELTA_W-1:0] angle_delta;
  } out_beat_t;

  // Divider request and status
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [T_W-1:0]       den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILT_A,
    S_FILT_B,
    S_FILT_C,
    S_ERR,
    S_PROP,
    S_DGAIN,
    S_DLO,
    S_DHI,
    S_DSUM,
    S_DIV,
    S_TOTAL,
    S_DONE
  } state_t;

endpackage

FILE: hdl/filtered_pd_servo_angle_core.sv
// Filtered PD servo angle controller: low-pass filter, PD step, clamped angle.
// An empty filter loads the sample directly and skips the blend states S_FILT_B and S_FILT_C.
// A new beat is accepted only in S_IDLE, after the serial divide and the result load; a held result stalls it.
// One shared 19x22 multiplier serves the filter, both gains and the 1e6 time scaling.
// Reset: registers return to defaults, filtered level and last error clear, angle goes to 90.
// Depends on fpsa_pkg, fpsa_div and filtered_pd_servo_angle_core_assert.svh.
`include "filtered_pd_servo_angle_core_assert.svh"

module filtered_pd_servo_angle_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fpsa_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fpsa_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fpsa_pkg::out_beat_t             out_data
);

  fpsa_pkg::state_t state, state_next;

  // Configuration
  logic [fpsa_pkg::SAMPLE_W-1:0] target_mv;
  logic [15:0]                   filter_alpha;
  logic [15:0]                   prop_gain;
  logic [15:0]                   deriv_gain;

  // Controller state
  logic [fpsa_pkg::FL_W-1:0]         fl;
  logic signed [fpsa_pkg::ERR_W-1:0] last_err;
  logic [fpsa_pkg::ANGLE_W-1:0]      angle_now;
  logic                              seen_first;

  // Per-beat working registers
  logic [fpsa_pkg::SAMPLE_W-1:0]      sample;
  logic [fpsa_pkg::T_W-1:0]           t_us;
  logic [fpsa_pkg::ACC_W-1:0]         acc;
  logic signed [fpsa_pkg::ERR_W-1:0]  err;
  logic signed [fpsa_pkg::DERR_W-1:0] derr;
  logic [fpsa_pkg::PMAG_W-1:0]        pmag;
  logic [fpsa_pkg::DGM_W-1:0]         dgm;
  logic [fpsa_pkg::DLO_W-1:0]         dlo;
  logic [fpsa_pkg::PROD_W-1:0]        prod;
  logic signed [fpsa_pkg::TOT_W-1:0]  total;

  // Combinational helpers
  logic [15:0]                        alpha_eff;
  logic [fpsa_pkg::MUL_A_W-1:0]       mul_a;
  logic [fpsa_pkg::MUL_B_W-1:0]       mul_b;
  logic [fpsa_pkg::ERR_W-1:0]         err_mag;
  logic [fpsa_pkg::DERR_W-1:0]        derr_mag;
  logic [fpsa_pkg::ACC_W-1:0]         acc_sum;
  logic signed [fpsa_pkg::ERR_W-1:0]  err_calc;
  logic signed [fpsa_pkg::DERR_W-1:0] derr_calc;
  logic signed [fpsa_pkg::TOT_W-1:0]  p_signed;
  logic signed [fpsa_pkg::TOT_W-1:0]  d_signed;
  logic [fpsa_pkg::TOT_W-1:0]         tmag;
  logic [fpsa_pkg::DM_W-1:0]          dm;
  logic [fpsa_pkg::ANGLE_W-1:0]       angle_new;
  logic [fpsa_pkg::DELTA_W-1:0]       delta_sat;
  logic [fpsa_pkg::T_W-1:0]           t_sel;
  logic                               in_beat;
  logic                               out_free;

  fpsa_pkg::div_req_t div_req;
  fpsa_pkg::div_rsp_t div_rsp;

  assign in_ready = (state == fpsa_pkg::S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_mv    <= fpsa_pkg::TARGET_RST;
      filter_alpha <= fpsa_pkg::ALPHA_RST;
      prop_gain    <= fpsa_pkg::PGAIN_RST;
      deriv_gain   <= fpsa_pkg::DGAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fpsa_pkg::CFG_TARGET: target_mv    <= cfg_data[fpsa_pkg::SAMPLE_W-1:0];
        fpsa_pkg::CFG_ALPHA:  filter_alpha <= cfg_data;
        fpsa_pkg::CFG_PGAIN:  prop_gain    <= cfg_data;
        fpsa_pkg::CFG_DGAIN:  deriv_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate alpha at one, pick the effective sample interval
  always_comb begin
    alpha_eff = (filter_alpha > fpsa_pkg::ALPHA_ONE) ? fpsa_pkg::ALPHA_ONE : filter_alpha;
    if (!seen_first || in_data.elapsed_us == '0 || in_data.elapsed_us > fpsa_pkg::MAX_T) begin
      t_sel = fpsa_pkg::DEFAULT_T;
    end else begin
      t_sel = in_data.elapsed_us[fpsa_pkg::T_W-1:0];
    end
  end

  // Error, magnitudes and filter sum
  always_comb begin
    err_calc  = $signed({1'b0, target_mv, 8'b0}) - $signed({1'b0, fl});
    derr_calc = $signed({err_calc[fpsa_pkg::ERR_W-1], err_calc})
              - $signed({last_err[fpsa_pkg::ERR_W-1], last_err});
    err_mag   = err[fpsa_pkg::ERR_W-1] ? fpsa_pkg::ERR_W'(-err) : fpsa_pkg::ERR_W'(err);
    derr_mag  = derr[fpsa_pkg::DERR_W-1] ? fpsa_pkg::DERR_W'(-derr) : fpsa_pkg::DERR_W'(derr);
    acc_sum   = acc + prod[fpsa_pkg::ACC_W-1:0] + fpsa_pkg::ROUND_HALF;
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      fpsa_pkg::S_FILT_A: begin
        mul_a = fpsa_pkg::MUL_A_W'(alpha_eff);
        mul_b = fpsa_pkg::MUL_B_W'({sample, 8'b0});
      end
      fpsa_pkg::S_FILT_B: begin
        mul_a = fpsa_pkg::MUL_A_W'(fpsa_pkg::ALPHA_ONE - alpha_eff);
        mul_b = fpsa_pkg::MUL_B_W'(fl);
      end
      fpsa_pkg::S_PROP: begin
        mul_a = fpsa_pkg::MUL_A_W'(prop_gain);
        mul_b = fpsa_pkg::MUL_B_W'(err_mag);
      end
      fpsa_pkg::S_DGAIN: begin
        mul_a = fpsa_pkg::MUL_A_W'(deriv_gain);
        mul_b = derr_mag;
      end
      fpsa_pkg::S_DLO: begin
        mul_a = prod[fpsa_pkg::SPLIT_W-1:0];
        mul_b = fpsa_pkg::US_PER_S;
      end
      fpsa_pkg::S_DHI: begin
        mul_a = dgm[fpsa_pkg::DGM_W-1:fpsa_pkg::SPLIT_W];
        mul_b = fpsa_pkg::US_PER_S;
      end
      default: ;
    endcase
  end

  // Register every product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divider hookup: scaled derivative over elapsed time
  always_comb begin
    div_req.start = (state == fpsa_pkg::S_DSUM);
    div_req.num   = {prod[fpsa_pkg::DLO_W-1:0], {fpsa_pkg::SPLIT_W{1'b0}}}
                  + fpsa_pkg::DIV_NUM_W'(dlo);
    div_req.den   = t_us;
  end

  fpsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Signed sum, then magnitude, integer degrees, clamp and saturation
  always_comb begin
    p_signed = err[fpsa_pkg::ERR_W-1] ? -$signed(fpsa_pkg::TOT_W'(pmag))
                                      :  $signed(fpsa_pkg::TOT_W'(pmag));
    d_signed = derr[fpsa_pkg::DERR_W-1] ? -$signed(fpsa_pkg::TOT_W'(div_rsp.quot))
                                        :  $signed(fpsa_pkg::TOT_W'(div_rsp.quot));
    tmag     = total[fpsa_pkg::TOT_W-1] ? fpsa_pkg::TOT_W'(-total) : fpsa_pkg::TOT_W'(total);
    dm       = tmag[fpsa_pkg::TOT_W-1:fpsa_pkg::FRAC_SH];
    if (total[fpsa_pkg::TOT_W-1]) begin
      angle_new = (dm >= fpsa_pkg::DM_W'(angle_now)) ? '0
                : angle_now - dm[fpsa_pkg::ANGLE_W-1:0];
      delta_sat = (dm > fpsa_pkg::DM_W'(32768)) ? 16'h8000
                : fpsa_pkg::DELTA_W'(-dm[fpsa_pkg::DELTA_W:0]);
    end else begin
      angle_new = (dm >= fpsa_pkg::DM_W'(fpsa_pkg::ANGLE_MAX - angle_now)) ? fpsa_pkg::ANGLE_MAX
                : angle_now + dm[fpsa_pkg::ANGLE_W-1:0];
      delta_sat = (dm > fpsa_pkg::DM_W'(32767)) ? 16'h7FFF : dm[fpsa_pkg::DELTA_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpsa_pkg::S_IDLE:   if (in_beat) state_next = fpsa_pkg::S_FILT_A;
      fpsa_pkg::S_FILT_A: state_next = (fl == '0) ? fpsa_pkg::S_ERR : fpsa_pkg::S_FILT_B;
      fpsa_pkg::S_FILT_B: state_next = fpsa_pkg::S_FILT_C;
      fpsa_pkg::S_FILT_C: state_next = fpsa_pkg::S_ERR;
      fpsa_pkg::S_ERR:    state_next = fpsa_pkg::S_PROP;
      fpsa_pkg::S_PROP:   state_next = fpsa_pkg::S_DGAIN;
      fpsa_pkg::S_DGAIN:  state_next = fpsa_pkg::S_DLO;
      fpsa_pkg::S_DLO:    state_next = fpsa_pkg::S_DHI;
      fpsa_pkg::S_DHI:    state_next = fpsa_pkg::S_DSUM;
      fpsa_pkg::S_DSUM:   state_next = fpsa_pkg::S_DIV;
      fpsa_pkg::S_DIV:    if (div_rsp.done) state_next = fpsa_pkg::S_TOTAL;
      fpsa_pkg::S_TOTAL:  state_next = fpsa_pkg::S_DONE;
      fpsa_pkg::S_DONE:   if (out_free) state_next = fpsa_pkg::S_IDLE;
      default:            state_next = fpsa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Controller state: filter, last error, angle
  always_ff @(posedge clk) begin
    if (rst) begin
      fl         <= '0;
      last_err   <= '0;
      angle_now  <= fpsa_pkg::ANGLE_RESET;
      seen_first <= 1'b0;
    end else begin
      if (state == fpsa_pkg::S_FILT_A && fl == '0) begin
        fl <= {sample, 8'b0};
      end else if (state == fpsa_pkg::S_FILT_C) begin
        fl <= acc_sum[fpsa_pkg::FILT_SH +: fpsa_pkg::FL_W];
      end
      if (state == fpsa_pkg::S_DONE && out_free) begin
        last_err   <= err;
        angle_now  <= angle_new;
        seen_first <= 1'b1;
      end
    end
  end

  // Working registers along the sequence
  always_ff @(posedge clk) begin
    if (in_beat) begin
      sample <= in_data.sample_mv;
      t_us   <= t_sel;
    end
    if (state == fpsa_pkg::S_FILT_B) acc <= prod[fpsa_pkg::ACC_W-1:0];
    if (state == fpsa_pkg::S_ERR) begin
      err  <= err_calc;
      derr <= derr_calc;
    end
    if (state == fpsa_pkg::S_DGAIN) pmag <= prod[fpsa_pkg::PMAG_W-1:0];
    if (state == fpsa_pkg::S_DLO)   dgm  <= prod[fpsa_pkg::DGM_W-1:0];
    if (state == fpsa_pkg::S_DHI)   dlo  <= prod[fpsa_pkg::DLO_W-1:0];
    if (state == fpsa_pkg::S_TOTAL) total <= p_signed + d_signed;
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == fpsa_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fpsa_pkg::S_DONE && out_free) begin
      out_data.servo_angle <= angle_new;
      out_data.angle_delta <= $signed(delta_sat);
    end
  end

  // Checks
  `FPSA_ASSERT_NOW(a_angle_range, 1'b1, angle_now <= fpsa_pkg::ANGLE_MAX, "angle above limit")
  `FPSA_ASSERT_NOW(a_out_range, out_valid, out_data.servo_angle <= fpsa_pkg::ANGLE_MAX, "output angle above limit")
  `FPSA_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready after accepted beat")
  `FPSA_ASSERT_NEXT(a_result_loaded, state == fpsa_pkg::S_DONE && (!out_valid || out_ready), out_valid, "result not presented")

endmodule

FILE: hdl/fpsa_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on fpsa_pkg for widths and the request/status structs.
module fpsa_div (
  input  logic               clk,
  input  logic               rst,
  input  fpsa_pkg::div_req_t req,
  output fpsa_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [fpsa_pkg::DIV_CNT_W-1:0] cnt;
  logic [fpsa_pkg::DIV_NUM_W-1:0] quo;
  logic [fpsa_pkg::T_W-1:0]       rem;
  logic [fpsa_pkg::T_W-1:0]       den;
  logic [fpsa_pkg::T_W:0]         rem_shift;
  logic [fpsa_pkg::T_W:0]         rem_diff;
  logic                           ge;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_shift = {rem, quo[fpsa_pkg::DIV_NUM_W-1]};
    rem_diff  = rem_shift - {1'b0, den};
    ge        = (rem_shift >= {1'b0, den});
  end

  // Control: load, count down, flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= fpsa_pkg::DIV_CNT_W'(fpsa_pkg::DIV_NUM_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? rem_diff[fpsa_pkg::T_W-1:0] : rem_shift[fpsa_pkg::T_W-1:0];
      quo <= {quo[fpsa_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

FILE: bench/filtered_pd_servo_angle_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for filtered_pd_servo_angle_core: directed and random millivolt samples,
// predicted angle and delta compared per beat. Depends on fpsa_pkg and the core RTL.

// Predict angle and delta per sample beat; hold expected beats until the core returns them
class servo_angle_book;
  localparam int ALPHA_UNITY = 32768;
  localparam int T_DEFAULT   = 10000;
  localparam int T_LONGEST   = 100000;
  localparam int ANGLE_TOP   = 180;

  // register copies
  bit [11:0] target_mv;
  bit [15:0] alpha;
  bit [15:0] prop_gain;
  bit [15:0] deriv_gain;

  // controller state
  bit [19:0] level;
  int        last_err;
  int        angle_now;
  bit        seen_first;

  fpsa_pkg::out_beat_t expected_angles[$];
  int mismatches;

  function new();
    target_mv  = 12'd3;
    alpha      = 16'd3277;
    prop_gain  = 16'd655;
    deriv_gain = 16'd66;
    level      = '0;
    last_err   = 0;
    angle_now  = 90;
    seen_first = 1'b0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [fpsa_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      fpsa_pkg::CFG_TARGET: target_mv  = data[11:0];
      fpsa_pkg::CFG_ALPHA:  alpha      = data;
      fpsa_pkg::CFG_PGAIN:  prop_gain  = data;
      fpsa_pkg::CFG_DGAIN:  deriv_gain = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_angles.size();
  endfunction

  // Advance the filter and PD step for one accepted sample beat
  function void note_sample(fpsa_pkg::in_beat_t b);
    int                 t_us;
    int                 a;
    bit [63:0]          acc;
    int                 err;
    int                 derr;
    bit [21:0]          emag;
    bit [21:0]          dmag_in;
    longint unsigned    pmag;
    longint unsigned    dmag;
    longint             total;
    longint             delta;
    longint             ang;
    fpsa_pkg::out_beat_t want;

    // fall back to the default period on the first beat or a bad elapsed time
    if (!seen_first || b.elapsed_us == 0 || int'(b.elapsed_us) > T_LONGEST) begin
      t_us = T_DEFAULT;
    end else begin
      t_us = int'(b.elapsed_us);
    end

    // load an empty filter directly, otherwise blend with rounding
    a = (int'(alpha) > ALPHA_UNITY) ? ALPHA_UNITY : int'(alpha);
    if (level == 0) begin
      level = {b.sample_mv, 8'h00};
    end else begin
      acc = 64'(a) * 64'({b.sample_mv, 8'h00}) + 64'(ALPHA_UNITY - a) * 64'(level)
            + 64'd16384;
      level = acc[34:15];
    end

    err  = int'({target_mv, 8'h00}) - int'(level);
    derr = err - last_err;
    emag    = (err < 0) ? 22'(-err) : 22'(err);
    dmag_in = (derr < 0) ? 22'(-derr) : 22'(derr);

    pmag = 64'(prop_gain) * 64'(emag);
    dmag = 64'(deriv_gain) * 64'(dmag_in);
    dmag = dmag * 64'd1000000 / 64'(t_us);

    total = ((err < 0) ? -$signed(pmag) : $signed(pmag))
          + ((derr < 0) ? -$signed(dmag) : $signed(dmag));
    // truncate toward zero to whole degrees
    if (total < 0) begin
      delta = -((-total) >>> 24);
    end else begin
      delta = total >>> 24;
    end

    ang = longint'(angle_now) + delta;
    if (ang < 0) ang = 0;
    if (ang > ANGLE_TOP) ang = ANGLE_TOP;
    angle_now  = int'(ang);
    last_err   = err;
    seen_first = 1'b1;

    if (delta > 32767) delta = 32767;
    if (delta < -32768) delta = -32768;

    want.servo_angle = 8'(angle_now);
    want.angle_delta = 16'(delta);
    expected_angles.push_back(want);
  endfunction

  // Compare one returned beat against the oldest prediction
  function void check_angle(fpsa_pkg::out_beat_t got);
    fpsa_pkg::out_beat_t want;
    if (expected_angles.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result beat angle %0d delta %0d", $time,
               got.servo_angle, got.angle_delta);
      return;
    end
    want = expected_angles.pop_front();
    if (got.servo_angle !== want.servo_angle) begin
      mismatches++;
      $display("%0t: servo_angle expected %0d, got %0d", $time,
               want.servo_angle, got.servo_angle);
    end
    if (got.angle_delta !== want.angle_delta) begin
      mismatches++;
      $display("%0t: angle_delta expected %0d, got %0d", $time,
               want.angle_delta, got.angle_delta);
    end
  endfunction
endclass

module filtered_pd_servo_angle_core_tb;

  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RAND_PER_SET = 42;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [fpsa_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [fpsa_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  fpsa_pkg::in_beat_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  fpsa_pkg::out_beat_t            out_data;

  int tx_idle_pct = 29;
  int rx_idle_pct = 88;
  int cycles = 0;

  servo_angle_book book = new();

  filtered_pd_servo_angle_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      book.check_angle(out_data);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one sample beat after a random gap and hold it until accepted
  task automatic push_sample(input logic [fpsa_pkg::SAMPLE_W-1:0] mv,
                             input logic [fpsa_pkg::ELAPSED_W-1:0] us);
    fpsa_pkg::in_beat_t beat;
    beat.sample_mv  = mv;
    beat.elapsed_us = us;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_sample(beat);
  endtask

  // Drop valid and wait until every predicted beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers while the core is idle
  task automatic load_regs(input logic [15:0] target, input logic [15:0] alpha,
                           input logic [15:0] pgain, input logic [15:0] dgain);
    logic [15:0] vals[4];
    logic [fpsa_pkg::CFG_IDX_W-1:0] idxs[4];
    drain_results();
    vals = '{target, alpha, pgain, dgain};
    idxs = '{fpsa_pkg::CFG_TARGET, fpsa_pkg::CFG_ALPHA, fpsa_pkg::CFG_PGAIN,
             fpsa_pkg::CFG_DGAIN};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      book.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] r_target;
    logic [15:0] r_alpha;
    logic [15:0] r_pgain;
    logic [15:0] r_dgain;
    logic [fpsa_pkg::SAMPLE_W-1:0]  mv;
    logic [fpsa_pkg::ELAPSED_W-1:0] us;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: first beat ignores elapsed time, then bad and boundary periods
    push_sample(12'd2048, 24'd50);
    push_sample(12'd2048, 24'd0);
    push_sample(12'd1000, 24'd100001);
    push_sample(12'd4095, 24'hFFFFFF);
    push_sample(12'd0, 24'd100000);
    push_sample(12'd4095, 24'd1);

    // Full-weight alpha decays the filter to zero; next beat reloads it; huge deltas saturate
    load_regs(16'hFFFF, 16'd32768, 16'hFFFF, 16'hFFFF);
    push_sample(12'd0, 24'd1);
    push_sample(12'd4095, 24'd1);
    push_sample(12'd0, 24'd1);
    push_sample(12'd4095, 24'd1);
    push_sample(12'd0, 24'hFFFFFF);

    // Alpha above one saturates; zero gains and zero target
    load_regs(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    push_sample(12'd4095, 24'd5000);
    push_sample(12'd123, 24'd77);

    // Zero alpha freezes the filter
    load_regs(16'd2000, 16'd0, 16'd30000, 16'd1000);
    push_sample(12'd0, 24'd20000);
    push_sample(12'd4095, 24'd99999);
    push_sample(12'd2000, 24'd1);

    // Random part: three idling patterns, several register settings each
    for (int mode = 0; mode < 3; mode++) begin
      drain_results();
      case (mode)
        0: begin tx_idle_pct = 29; rx_idle_pct = 88; end
        1: begin tx_idle_pct = 88; rx_idle_pct = 29; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int set = 0; set < 4; set++) begin
        case ($urandom_range(3))
          0: r_target = 16'h0000;
          1: r_target = 16'hFFFF;
          default: r_target = 16'($urandom_range(16'hFFFF));
        endcase
        case ($urandom_range(4))
          0: r_alpha = 16'd0;
          1: r_alpha = 16'd32768;
          2: r_alpha = 16'($urandom_range(32769, 65535));
          default: r_alpha = 16'($urandom_range(1, 32767));
        endcase
        case ($urandom_range(3))
          0: r_pgain = 16'd0;
          1: r_pgain = 16'hFFFF;
          default: r_pgain = 16'($urandom_range(1, 4000));
        endcase
        case ($urandom_range(3))
          0: r_dgain = 16'd0;
          1: r_dgain = 16'hFFFF;
          default: r_dgain = 16'($urandom_range(1, 2000));
        endcase
        load_regs(r_target, r_alpha, r_pgain, r_dgain);
        for (int n = 0; n < RAND_PER_SET; n++) begin
          case ($urandom_range(9))
            0: mv = 12'd0;
            1: mv = 12'd4095;
            default: mv = 12'($urandom_range(4095));
          endcase
          case ($urandom_range(9))
            0: us = 24'd0;
            1: us = 24'($urandom_range(100001, 24'hFFFFFF));
            2: us = 24'd100000;
            3: us = 24'($urandom_range(1, 100));
            default: us = 24'($urandom_range(1, 100000));
          endcase
          push_sample(mv, us);
        end
      end
    end

    drain_results();
    if (book.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
